[rtl/core/hmbp_pkg.sv]
// ============================================================================
// hmbp_pkg
// Shared constants and types for the hash message block padder.
// ============================================================================
`default_nettype none

package hmbp_pkg;

   // Default block size in bytes. It must be a power of two and at least 16.
   localparam int BLOCK_BYTES_DEF = 64;

   localparam int         COUNT_W   = 61;      // message byte count width
   localparam int         BYTE_W    = 8;
   localparam int         WORD_W    = 64;
   localparam int         IDX_W     = 3;       // word_index field width
   localparam int         LEN_BYTES = 8;       // length field bytes
   localparam logic [7:0] PAD_MARK  = 8'h80;

   // Emit-side control handed to the word composer
   typedef struct packed {
      logic fin;       // emitting the padded tail of a message
      logic second;    // second padded block (zeros plus length)
      logic two_blk;   // tail leaves no room for the length field
      logic len_le;    // length field little endian
   } hmbp_ctl_type;

endpackage : hmbp_pkg

`default_nettype wire

[rtl/core/hmbp_word_mux.sv]
// ============================================================================
// hmbp_word_mux
// Builds one outgoing block word: stored data, the partial tail word with
// the 0x80 mark, zero fill, or the bit length field.
// ============================================================================
`default_nettype none

module hmbp_word_mux
   import hmbp_pkg::*;
#(
   parameter int WORDS = BLOCK_BYTES_DEF / 8
) (
   input  hmbp_ctl_type                 ctl,
   input  logic [$clog2(WORDS)-1:0]     word_sel,   // word being emitted
   input  logic [$clog2(WORDS)-1:0]     cur_word,   // word holding the tail
   input  logic [2:0]                   tail_bytes, // bytes already in tail
   input  logic [WORD_W-BYTE_W-1:0]     asm_bytes,  // tail bytes, newest low
   input  logic [WORD_W-1:0]            mem_word,
   input  logic [WORD_W-1:0]            bit_len,
   output logic [WORD_W-1:0]            word
);

   localparam int WI_W = $clog2(WORDS);

   logic [WORD_W-1:0] tail_word;
   logic [WORD_W-1:0] len_word;
   logic              len_here;

   // Tail bytes moved to the top, followed by the mark and zeros
   assign tail_word = {asm_bytes, PAD_MARK} << {(3'd7 - tail_bytes), 3'b000};

   always_comb begin
      for (int i = 0; i < LEN_BYTES; i++) begin
         len_word[i*BYTE_W +: BYTE_W] = ctl.len_le ?
            bit_len[(LEN_BYTES-1-i)*BYTE_W +: BYTE_W] : bit_len[i*BYTE_W +: BYTE_W];
      end
   end

   assign len_here = ctl.fin && (ctl.second || !ctl.two_blk) &&
                     (word_sel == WI_W'(WORDS - 1));

   always_comb begin
      if (!ctl.fin) begin
         word = mem_word;
      end else if (len_here) begin
         word = len_word;
      end else if (ctl.second) begin
         word = '0;
      end else if (word_sel < cur_word) begin
         word = mem_word;
      end else if (word_sel == cur_word) begin
         word = tail_word;
      end else begin
         word = '0;
      end
   end

endmodule : hmbp_word_mux

`default_nettype wire

[rtl/core/hash_message_block_padder.sv]
// ============================================================================
// hash_message_block_padder
// Merkle-Damgard message blocker and padder: collects message bytes into
// 64-bit words in a word buffer, emits full blocks and pads the final one.
// ============================================================================
//
//  channel | ports       | dir | tdata / data               | tuser / tlast
//  --------+-------------+-----+----------------------------+-------------------
//  csr     | csr_*       | in  | length_little_endian       | -
//  req     | req_t*      | in  | data_byte                  | user: opcode
//  rsp     | rsp_t*      | out | block_word, word_index     | user: last_of_block
//          |             |     |                            | last: last_of_message
//
//  Bytes gather in an assembly register; every eighth byte writes one
//  word into the word buffer. A byte that fills the block, or a finish,
//  starts emission: WORDS words at one per cycle while rsp is not held,
//  from the word buffer's single read port, two blocks when the tail
//  leaves no room for the length. req is stalled meanwhile.
//  rsp is a registered output; emission stalls while it is held.
//  Reset (synchronous) clears the count, the control and the output valid;
//  the word buffer is not cleared.
// ============================================================================
`default_nettype none

module hash_message_block_padder
   import hmbp_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata,     // [0] length_little_endian
   // message bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] data_byte
   input  logic        req_tuser,     // [0] opcode (1 = finish)
   // block words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,     // [63:0] block_word, [66:64] word_index
   output logic        rsp_tuser,     // [0] last_of_block
   output logic        rsp_tlast      // last_of_message
);

   localparam int WORDS = BLOCK_BYTES / 8;
   localparam int POS_W = $clog2(BLOCK_BYTES);
   localparam int WI_W  = $clog2(WORDS);
   localparam int PAD_W = 72 - WORD_W - IDX_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SEND = 1'b1;

   // ---------------------------------------------------------------- state
   logic                      state_ff, state_in;
   logic [WI_W-1:0]           w_ff, w_in;
   logic                      fin_ff, fin_in;
   logic                      second_ff, second_in;
   logic                      len_le_ff;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [WORD_W-BYTE_W-1:0]  asm_ff;

   // word buffer
   logic [WORD_W-1:0]         mem [WORDS];
   logic [WORD_W-1:0]         rdata_ff;

   // output register
   logic                      rsp_valid_ff;
   logic [WORD_W-1:0]         rsp_word_ff;
   logic [IDX_W-1:0]          rsp_idx_ff;
   logic                      rsp_lob_ff;
   logic                      rsp_lom_ff;

   // ---------------------------------------------------------------- decode
   logic                 acc;
   logic                 is_fin;
   logic [POS_W-1:0]     pos;
   logic [WI_W-1:0]      cur_word;
   logic [2:0]           tail_bytes;
   logic                 wr_en;
   logic                 load;
   logic                 last_w;
   logic                 two_blk;
   logic [WORD_W-1:0]    bit_len;
   logic [WORD_W-1:0]    out_word;
   hmbp_ctl_type         ctl;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign is_fin     = req_tuser;

   assign pos        = count_ff[POS_W-1:0];
   assign cur_word   = pos[POS_W-1:3];
   assign tail_bytes = pos[2:0];
   assign two_blk    = (cur_word == WI_W'(WORDS - 1));
   assign bit_len    = {count_ff, 3'b000};

   // a full word goes to the buffer on every eighth byte
   assign wr_en  = acc && !is_fin && (tail_bytes == 3'd7);
   assign load   = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_tready);
   assign last_w = (w_ff == WI_W'(WORDS - 1));

   always_comb begin
      state_in  = state_ff;
      w_in      = w_ff;
      fin_in    = fin_ff;
      second_in = second_ff;
      count_in  = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (is_fin) begin
                  state_in  = ST_SEND;
                  fin_in    = 1'b1;
                  second_in = 1'b0;
               end else begin
                  count_in = count_ff + COUNT_W'(1);
                  if (pos == POS_W'(BLOCK_BYTES - 1)) begin
                     state_in = ST_SEND;
                     fin_in   = 1'b0;
                  end
               end
            end
         end
         ST_SEND: begin
            if (load) begin
               w_in = w_ff + WI_W'(1);
               if (last_w) begin
                  if (fin_ff && two_blk && !second_ff) begin
                     second_in = 1'b1;
                  end else begin
                     state_in  = ST_IDLE;
                     fin_in    = 1'b0;
                     second_in = 1'b0;
                     if (fin_ff) begin
                        count_in = '0;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         w_ff      <= '0;
         fin_ff    <= 1'b0;
         second_ff <= 1'b0;
         count_ff  <= '0;
         len_le_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         w_ff      <= w_in;
         fin_ff    <= fin_in;
         second_ff <= second_in;
         count_ff  <= count_in;
         if (csr_valid && csr_ready) begin
            len_le_ff <= csr_wdata;
         end
      end
   end

   // tail assembly: newest byte in the low lane
   always_ff @(posedge clock) begin
      if (acc && !is_fin) begin
         asm_ff <= {asm_ff[WORD_W-2*BYTE_W-1:0], req_tdata};
      end
   end

   // Word buffer. The read address follows the next word counter, so
   // rdata_ff always holds the word for w_ff. Writes only happen in idle
   // and never to word 0 on the edge that starts emission, so no bypass.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cur_word] <= {asm_ff, req_tdata};
      end
      rdata_ff <= mem[w_in];
   end

   // ---------------------------------------------------------------- compose
   assign ctl.fin     = fin_ff;
   assign ctl.second  = second_ff;
   assign ctl.two_blk = two_blk;
   assign ctl.len_le  = len_le_ff;

   hmbp_word_mux #(
      .WORDS (WORDS)
   ) u_word_mux (
      .ctl        (ctl),
      .word_sel   (w_ff),
      .cur_word   (cur_word),
      .tail_bytes (tail_bytes),
      .asm_bytes  (asm_ff),
      .mem_word   (rdata_ff),
      .bit_len    (bit_len),
      .word       (out_word)
   );

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= out_word;
         rsp_idx_ff  <= IDX_W'(w_ff);
         rsp_lob_ff  <= last_w;
         rsp_lom_ff  <= last_w && fin_ff && (second_ff || !two_blk);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_idx_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_lob_ff;
   assign rsp_tlast  = rsp_lom_ff;

   // ---------------------------------------------------------------- checks
   // byte that fills the block must start emission
   a_full_starts_send: assert property (@(posedge clock) disable iff (reset)
      (acc && !is_fin && pos == POS_W'(BLOCK_BYTES - 1)) |=> (state_ff == ST_SEND))
      else $error("full block did not start emission");

   // end of message always ends a block
   a_lom_is_lob: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("last_of_message without last_of_block");

   // last word of a block carries the final index
   a_lob_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[66:64] == IDX_W'(WORDS - 1)))
      else $error("last_of_block on wrong word index");

   // a finished message leaves the count cleared
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (load && last_w && fin_ff && (second_ff || !two_blk)) |=> (count_ff == '0))
      else $error("byte count not cleared after finish");

endmodule : hash_message_block_padder

`default_nettype wire
